// ===== design/circle_serpentine_row_chords_defines.svh =====
// ----------------------------------------------------------------------------
// circle_serpentine_row_chords_defines
// assertion macros shared by the row chord scanner
// ----------------------------------------------------------------------------
`ifndef CIRCLE_SERPENTINE_ROW_CHORDS_DEFINES_SVH
`define CIRCLE_SERPENTINE_ROW_CHORDS_DEFINES_SVH

// same-cycle implication, off while reset is low
`define CSRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define CSRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/csrc_pkg.sv =====
// ----------------------------------------------------------------------------
// csrc_pkg
// widths, register codes and shared types of the row chord scanner
// ----------------------------------------------------------------------------
package csrc_pkg;

    localparam int COORD_BITS = 24;
    localparam int RW         = COORD_BITS - 1;        // radius, pitch, margins
    localparam int OW         = COORD_BITS + 1;        // chord ends, row register
    localparam int WW         = COORD_BITS + 2;        // internal working width
    localparam int DW         = 2 * RW;                // radicand r^2 - h^2
    localparam int PPW        = COORD_BITS + 2;        // multiplicand times a digit

    localparam int MUL_DIGITS = (RW + 1) / 2;          // radix-4 digits of r - h
    localparam int MUL_AW     = 2 * MUL_DIGITS;
    localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);

    localparam int ROOT_STEPS = RW;                    // one root bit per step
    localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
    localparam int REM_W      = RW + 3;

    localparam int REG_COUNT  = 7;
    localparam int REG_IDX_W  = $clog2(REG_COUNT);
    localparam int ADDR_W     = REG_IDX_W + 2;
    localparam int DATA_W     = 32;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CENTER_X     = REG_IDX_W'(0),
        REG_CENTER_Y     = REG_IDX_W'(1),
        REG_RADIUS       = REG_IDX_W'(2),
        REG_FIRST_ROW_Y  = REG_IDX_W'(3),
        REG_ROW_PITCH    = REG_IDX_W'(4),
        REG_LEFT_MARGIN  = REG_IDX_W'(5),
        REG_RIGHT_MARGIN = REG_IDX_W'(6)
    } t_reg_idx;

    typedef struct packed {
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] center_y;
        logic [RW-1:0]         radius;
        logic [COORD_BITS-1:0] first_row_y;
        logic [RW-1:0]         row_pitch;
        logic [RW-1:0]         left_margin;
        logic [RW-1:0]         right_margin;
    } t_cfg;

    typedef struct packed {
        logic [RW-1:0] root;
        logic          inexact;
    } t_root;

endpackage

// ===== design/csrc_regs.sv =====
// ----------------------------------------------------------------------------
// csrc_regs
// register file of the row chord scanner behind an apb-style port
// ----------------------------------------------------------------------------
module csrc_regs
    import csrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{row_pitch: RW'(1), default: '0};
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CENTER_X:     r_cfg.center_x     <= pwdata[COORD_BITS-1:0];
                REG_CENTER_Y:     r_cfg.center_y     <= pwdata[COORD_BITS-1:0];
                REG_RADIUS:       r_cfg.radius       <= pwdata[RW-1:0];
                REG_FIRST_ROW_Y:  r_cfg.first_row_y  <= pwdata[COORD_BITS-1:0];
                REG_ROW_PITCH:    r_cfg.row_pitch    <= pwdata[RW-1:0];
                REG_LEFT_MARGIN:  r_cfg.left_margin  <= pwdata[RW-1:0];
                REG_RIGHT_MARGIN: r_cfg.right_margin <= pwdata[RW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CENTER_X:     prdata = DATA_W'(r_cfg.center_x);
            REG_CENTER_Y:     prdata = DATA_W'(r_cfg.center_y);
            REG_RADIUS:       prdata = DATA_W'(r_cfg.radius);
            REG_FIRST_ROW_Y:  prdata = DATA_W'(r_cfg.first_row_y);
            REG_ROW_PITCH:    prdata = DATA_W'(r_cfg.row_pitch);
            REG_LEFT_MARGIN:  prdata = DATA_W'(r_cfg.left_margin);
            REG_RIGHT_MARGIN: prdata = DATA_W'(r_cfg.right_margin);
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== design/csrc_mul.sv =====
// ----------------------------------------------------------------------------
// csrc_mul
// radix-4 serial multiplier, forms (r - h) * (r + h) two bits a cycle
// ----------------------------------------------------------------------------
module csrc_mul
    import csrc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [RW-1:0]         i_mplier,
    input  logic [COORD_BITS-1:0] i_mcand,
    output logic                  o_done,
    output logic [DW-1:0]         o_product
);

    logic                  r_busy;
    logic                  r_done;
    logic [MUL_CNT_W-1:0]  r_cnt;
    logic [MUL_AW-1:0]     r_mplier;
    logic [COORD_BITS-1:0] r_mcand;
    logic [PPW-1:0]        r_mcand3;
    logic [PPW-1:0]        pprod;
    logic [DW-1:0]         r_acc;

    // multiplier digits leave from the top, msb first
    always_comb begin
        unique case (r_mplier[MUL_AW-1 -: 2])
            2'd0: pprod = '0;
            2'd1: pprod = PPW'(r_mcand);
            2'd2: pprod = PPW'({r_mcand, 1'b0});
            2'd3: pprod = r_mcand3;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CNT_W'(MUL_DIGITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mplier <= MUL_AW'(i_mplier);
            r_mcand  <= i_mcand;
            r_mcand3 <= PPW'(i_mcand) + PPW'({i_mcand, 1'b0});
            r_acc    <= '0;
        end else if (r_busy) begin
            r_mplier <= {r_mplier[MUL_AW-3:0], 2'b00};
            r_acc    <= {r_acc[DW-3:0], 2'b00} + DW'(pprod);
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// ===== design/csrc_sqrt.sv =====
// ----------------------------------------------------------------------------
// csrc_sqrt
// digit-by-digit integer square root, one root bit a cycle
// ----------------------------------------------------------------------------
module csrc_sqrt
    import csrc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_radicand,
    output logic          o_done,
    output t_root         o_root
);

    logic                  r_busy;
    logic                  r_done;
    logic [ROOT_CNT_W-1:0] r_cnt;
    logic [DW-1:0]         r_rad;
    logic [REM_W-1:0]      r_rem;
    logic [RW-1:0]         r_root;

    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      trial;
    logic [REM_W:0]        diff;
    logic                  fits;

    // bring down the next radicand pair, try (root << 2) | 1
    assign rem_sh = {r_rem[REM_W-3:0], r_rad[DW-1 -: 2]};
    assign trial  = REM_W'({r_root, 2'b01});
    assign diff   = {1'b0, rem_sh} - {1'b0, trial};
    assign fits   = ~diff[REM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= ROOT_CNT_W'(ROOT_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[DW-3:0], 2'b00};
            r_rem  <= fits ? diff[REM_W-1:0] : rem_sh;
            r_root <= {r_root[RW-2:0], fits};
        end
    end

    assign o_done         = r_done;
    assign o_root.root    = r_root;
    assign o_root.inexact = |r_rem;

endmodule

// ===== design/circle_serpentine_row_chords.sv =====
// ----------------------------------------------------------------------------
// circle_serpentine_row_chords
// serpentine scan of horizontal chords across a circle, one row per request
// ----------------------------------------------------------------------------
// Usage:
//   input channel  i_in_valid / o_in_stall carries i_restart; a beat is taken
//   when valid is high and stall is low. restart = 1 reloads the first row and
//   heads left to right; restart = 0 asks for the next row.
//   output channel o_out_valid / i_out_stall carries one result beat per
//   request: line_found, chord_start_x, chord_end_x, chord_y.
//   one request is worked at a time. a row inside the circle passes through
//   the serial multiplier (two bits a cycle) and the square root (one bit a
//   cycle) before o_out_valid; a row outside the circle skips both. o_in_stall
//   falls in the same cycle that the result enters the output register.
//   the result sits in an output register, so a new request is taken while
//   the receiver stalls; a finished row waits in ST_DONE until the slot frees.
//   reset (synchronous, active low) restores the register defaults (pitch 1,
//   the rest 0), clears the scan state and empties the output register.
//   the user writes registers over the apb-style port only while no request
//   is open; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "circle_serpentine_row_chords_defines.svh"

module circle_serpentine_row_chords
    import csrc_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_W-1:0]            paddr,
    input  logic [DATA_W-1:0]            pwdata,
    output logic [DATA_W-1:0]            prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_restart,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_line_found,
    output logic signed [OW-1:0]         o_chord_start_x,
    output logic signed [OW-1:0]         o_chord_end_x,
    output logic signed [COORD_BITS-1:0] o_chord_y
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_ABS,
        ST_CMP,
        ST_MUL,
        ST_ROOT,
        ST_CLAMP,
        ST_DONE
    } t_state;

    t_cfg   cfg;
    t_root  root;
    logic   mul_done;
    logic   sqrt_done;
    logic   mul_start;
    logic   sqrt_start;
    logic [DW-1:0] product;

    t_state                r_state;
    logic [OW-1:0]         r_next_row_y;
    logic                  r_heading_left;
    logic                  r_scan_started;
    logic signed [WW-1:0]  r_h;
    logic signed [WW-1:0]  r_ledge;
    logic signed [WW-1:0]  r_redge;
    logic signed [WW-1:0]  r_lo;
    logic signed [WW-1:0]  r_hi;
    logic signed [WW-1:0]  r_start;
    logic signed [WW-1:0]  r_end;
    logic signed [WW-1:0]  r_adv;
    logic                  r_found;
    logic                  r_turn;
    logic                  r_out_valid;
    logic                  r_line_found;
    logic [OW-1:0]         r_start_x;
    logic [OW-1:0]         r_end_x;
    logic [COORD_BITS-1:0] r_chord_y;

    logic signed [WW-1:0]  cx_w;
    logic signed [WW-1:0]  cy_w;
    logic signed [WW-1:0]  rad_w;
    logic signed [WW-1:0]  row_w;
    logic signed [WW-1:0]  root_w;
    logic signed [WW-1:0]  span;
    logic signed [WW-1:0]  sum_rh;
    logic [OW-1:0]         first_ext;
    logic [OW-1:0]         y_sel;
    logic [OW-1:0]         adv_sat;
    logic [COORD_BITS-1:0] y_sat;
    logic                  line_ok;
    logic                  lo_below;
    logic                  hi_above;
    logic                  out_free;

    csrc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign cx_w      = {{(WW-COORD_BITS){cfg.center_x[COORD_BITS-1]}}, cfg.center_x};
    assign cy_w      = {{(WW-COORD_BITS){cfg.center_y[COORD_BITS-1]}}, cfg.center_y};
    assign rad_w     = {{(WW-RW){1'b0}}, cfg.radius};
    assign row_w     = {r_next_row_y[OW-1], r_next_row_y};
    assign root_w    = {{(WW-RW){1'b0}}, root.root};
    assign first_ext = {cfg.first_row_y[COORD_BITS-1], cfg.first_row_y};
    assign y_sel     = (i_restart || !r_scan_started) ? first_ext : r_next_row_y;

    // h is below r exactly when r - h is positive
    assign span    = rad_w - r_h;
    assign sum_rh  = rad_w + r_h;
    assign line_ok = ~span[WW-1] & (span != '0);

    assign mul_start  = (r_state == ST_CMP) && line_ok;
    assign sqrt_start = (r_state == ST_MUL) && mul_done;

    csrc_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mplier  (span[RW-1:0]),
        .i_mcand   (sum_rh[COORD_BITS-1:0]),
        .o_done    (mul_done),
        .o_product (product)
    );

    csrc_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (product),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    assign lo_below = r_lo < r_ledge;
    assign hi_above = r_hi > r_redge;

    // next row saturates at the top of the row register
    assign adv_sat = (!r_adv[WW-1] && r_adv[WW-2]) ? {1'b0, {COORD_BITS{1'b1}}}
                                                   : r_adv[OW-1:0];

    always_comb begin
        if (r_next_row_y[OW-1] != r_next_row_y[OW-2]) begin
            y_sat = r_next_row_y[OW-1] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                       : {1'b0, {(COORD_BITS-1){1'b1}}};
        end else begin
            y_sat = r_next_row_y[COORD_BITS-1:0];
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_next_row_y   <= '0;
            r_heading_left <= 1'b0;
            r_scan_started <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            // a finished row refills the slot in the cycle it drains
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_next_row_y <= y_sel;
                        if (i_restart) begin
                            r_heading_left <= 1'b0;
                            r_scan_started <= 1'b0;
                        end
                        r_state <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    r_h     <= cy_w - row_w;
                    r_ledge <= cx_w - rad_w;
                    r_redge <= cx_w + rad_w;
                    r_state <= ST_ABS;
                end
                ST_ABS: begin
                    r_h     <= r_h[WW-1] ? -r_h : r_h;
                    r_ledge <= r_ledge + WW'(cfg.left_margin);
                    r_redge <= r_redge - WW'(cfg.right_margin);
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    r_found <= 1'b0;
                    r_state <= line_ok ? ST_MUL : ST_DONE;
                end
                ST_MUL: begin
                    if (mul_done) begin
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (sqrt_done) begin
                        // right end rounds up when the root is inexact
                        r_lo    <= cx_w - root_w;
                        r_hi    <= cx_w + root_w + WW'(root.inexact);
                        r_found <= 1'b1;
                        r_state <= ST_CLAMP;
                    end
                end
                ST_CLAMP: begin
                    if (!r_heading_left) begin
                        r_start <= lo_below ? r_ledge : r_lo;
                        r_end   <= hi_above ? r_redge : r_hi;
                        r_turn  <= r_redge >= cx_w;
                    end else begin
                        r_start <= hi_above ? r_redge : r_hi;
                        r_end   <= lo_below ? r_ledge : r_lo;
                        r_turn  <= r_ledge >= cx_w;
                    end
                    r_adv   <= row_w + WW'(cfg.row_pitch);
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_line_found <= r_found;
                        r_start_x    <= r_found ? r_start[OW-1:0] : '0;
                        r_end_x      <= r_found ? r_end[OW-1:0] : '0;
                        r_chord_y    <= r_found ? y_sat : '0;
                        if (r_found) begin
                            r_scan_started <= 1'b1;
                            r_heading_left <= r_turn;
                            r_next_row_y   <= adv_sat;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_line_found    = r_line_found;
    assign o_chord_start_x = r_start_x;
    assign o_chord_end_x   = r_end_x;
    assign o_chord_y       = r_chord_y;

    `CSRC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "request taken but sequencer did not start")
    `CSRC_ASSERT_NOW(a_no_line_zero, i_clk, i_rst_n, o_out_valid && !o_line_found, (o_chord_start_x == '0) && (o_chord_end_x == '0) && (o_chord_y == '0), "no-line beat carries nonzero fields")
    `CSRC_ASSERT_NOW(a_start_with_chord, i_clk, i_rst_n, $rose(r_scan_started), o_out_valid && o_line_found, "scan marked started without a chord beat")

endmodule
